/* hdl/lcs_pkg.sv */
// Shared types and constants for the LRU cache set.
// Used by the controller, the datapath and the top level.
package lcs_pkg;

  localparam int WAYS      = 8;
  localparam int TAG_BITS  = 32;

  // Tags arrive 32 bits wide; only the low TAG_BITS of them are kept.
  localparam int KEY_BITS  = (TAG_BITS < 32) ? TAG_BITS : 32;
  localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_BITS  = WAY_BITS;
  localparam int OCC_BITS  = $clog2(WAYS + 1);
  localparam int CNT_BITS  = (OCC_BITS > 4) ? OCC_BITS : 4;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WAYS_IN_USE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WRITE_ALLOCATE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WRITE_BACK     = 2'd2;

  typedef struct packed {
    logic capture;  // latch the accepted item
    logic look;     // tag compare and victim search
    logic commit;   // update the set and load the result register
  } lcs_cmd_t;

endpackage

/* hdl/lcs_in_if.sv */
// Access channel: one item is a tag and a load/store flag.
// Depends on nothing but the handshake convention (valid and ready).
interface lcs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] tag;
  logic        is_write;

  modport source (output valid, output tag, output is_write, input ready);
  modport sink   (input valid, input tag, input is_write, output ready);
endinterface

/* hdl/lcs_out_if.sv */
// Result channel: hit flag and eviction report for one access.
// Depends on nothing but the handshake convention (valid and ready).
interface lcs_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        evicted;
  logic        evicted_dirty;
  logic [31:0] evicted_tag;

  modport source (output valid, output hit, output evicted, output evicted_dirty,
                  output evicted_tag, input ready);
  modport sink   (input valid, input hit, input evicted, input evicted_dirty,
                  input evicted_tag, output ready);
endinterface

/* hdl/lcs_ctrl.sv */
// Sequencer for the cache set: idle, lookup, update, plus the result valid flag.
// Uses lcs_pkg for the command struct.
module lcs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output lcs_pkg::lcs_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       commit;
  logic       capture;

  // Commit only when the result register is free or being emptied.
  assign commit   = (state_r == S_UPD) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE) || commit;
  assign capture  = in_valid && in_ready;

  assign cmd.capture = capture;
  assign cmd.look    = (state_r == S_LOOK);
  assign cmd.commit  = commit;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (capture) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (commit) state_nxt = capture ? S_LOOK : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/lcs_dp.sv */
// Datapath of the cache set: entry store, config registers, lookup and LRU update.
// Uses lcs_pkg for widths, config indexes and the command struct.
module lcs_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lcs_pkg::lcs_cmd_t                  cmd,
  input  logic [31:0]                        in_tag,
  input  logic                               in_is_write,
  input  logic                               cfg_we,
  input  logic [lcs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [lcs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic                               res_hit,
  output logic                               res_evicted,
  output logic                               res_evicted_dirty,
  output logic [31:0]                        res_evicted_tag
);

  localparam int W  = lcs_pkg::WAYS;
  localparam int WB = lcs_pkg::WAY_BITS;
  localparam int AB = lcs_pkg::AGE_BITS;
  localparam int KB = lcs_pkg::KEY_BITS;
  localparam int OB = lcs_pkg::OCC_BITS;
  localparam int CB = lcs_pkg::CNT_BITS;

  // Config registers
  logic [3:0] ways_in_use_r;
  logic       write_allocate_r;
  logic       write_back_r;

  // Entry store
  logic [W-1:0]  valid_r, valid_nxt;
  logic [W-1:0]  dirty_r, dirty_nxt;
  logic [AB-1:0] age_r   [W];
  logic [AB-1:0] age_nxt [W];
  logic [KB-1:0] tag_r   [W];
  logic [OB-1:0] occ_r, occ_nxt;

  // Request
  logic [KB-1:0] req_tag_r;
  logic          req_wr_r;

  // Lookup results
  logic          hit_r;
  logic [WB-1:0] hit_idx_r;
  logic [AB-1:0] hit_age_r;
  logic          free_found_r;
  logic [WB-1:0] free_idx_r;
  logic          vic_found_r;
  logic [WB-1:0] vic_idx_r;
  logic [KB-1:0] vic_tag_r;
  logic          vic_dirty_r;

  // Result register
  logic          res_hit_r, res_ev_r, res_evd_r;
  logic [31:0]   res_evt_r;

  // Lookup combinational
  logic          hit_c;
  logic [WB-1:0] hit_idx_c;
  logic          free_c;
  logic [WB-1:0] free_idx_c;
  logic          vic_c;
  logic [WB-1:0] vic_idx_c;
  logic [AB-1:0] vic_best_c;

  // Commit combinational
  logic [CB-1:0] cap_c;
  logic          alloc_c;
  logic          ev_c;
  logic [WB-1:0] slot_c;
  logic          wr_tag_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_in_use_r    <= 4'd8;
      write_allocate_r <= 1'b1;
      write_back_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcs_pkg::CFG_WAYS_IN_USE:    ways_in_use_r    <= cfg_data;
        lcs_pkg::CFG_WRITE_ALLOCATE: write_allocate_r <= cfg_data[0];
        lcs_pkg::CFG_WRITE_BACK:     write_back_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_tag_r <= in_tag[KB-1:0];
      req_wr_r  <= in_is_write;
    end
  end

  // Parallel tag compare and first free slot
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    free_c     = 1'b0;
    free_idx_c = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == req_tag_r) begin
        hit_c     = 1'b1;
        hit_idx_c = WB'(i);
      end
      if (!valid_r[i]) begin
        free_c     = 1'b1;
        free_idx_c = WB'(i);
      end
    end
  end

  // Lowest index wins a tie on age
  always_comb begin
    vic_c      = 1'b0;
    vic_idx_c  = '0;
    vic_best_c = '0;
    for (int i = 0; i < W; i++) begin
      if (valid_r[i] && (!vic_c || age_r[i] > vic_best_c)) begin
        vic_c      = 1'b1;
        vic_idx_c  = WB'(i);
        vic_best_c = age_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      hit_r        <= hit_c;
      hit_idx_r    <= hit_idx_c;
      hit_age_r    <= age_r[hit_idx_c];
      free_found_r <= free_c;
      free_idx_r   <= free_idx_c;
      vic_found_r  <= vic_c;
      vic_idx_r    <= vic_idx_c;
      vic_tag_r    <= tag_r[vic_idx_c];
      vic_dirty_r  <= dirty_r[vic_idx_c];
    end
  end

  // Clamp capacity to 1..WAYS
  always_comb begin
    if (ways_in_use_r == 4'd0) cap_c = CB'(1);
    else if (CB'(ways_in_use_r) > CB'(W)) cap_c = CB'(W);
    else cap_c = CB'(ways_in_use_r);
  end

  always_comb begin
    alloc_c = !hit_r && (!req_wr_r || write_allocate_r);
    ev_c    = 1'b0;
    slot_c  = '0;
    if (CB'(occ_r) < cap_c && free_found_r) begin
      slot_c = free_idx_r;
    end else if (vic_found_r) begin
      ev_c   = 1'b1;
      slot_c = vic_idx_r;
    end
    ev_c = ev_c && alloc_c;
  end

  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    occ_nxt   = occ_r;
    wr_tag_c  = 1'b0;
    for (int i = 0; i < W; i++) begin
      age_nxt[i] = age_r[i];
    end
    if (cmd.commit) begin
      if (hit_r) begin
        for (int i = 0; i < W; i++) begin
          if (valid_r[i] && age_r[i] < hit_age_r) age_nxt[i] = age_r[i] + AB'(1);
        end
        age_nxt[hit_idx_r] = '0;
        if (req_wr_r && write_back_r) dirty_nxt[hit_idx_r] = 1'b1;
      end else if (alloc_c) begin
        for (int i = 0; i < W; i++) begin
          if (valid_r[i]) age_nxt[i] = age_r[i] + AB'(1);
        end
        valid_nxt[slot_c] = 1'b1;
        dirty_nxt[slot_c] = req_wr_r && write_back_r;
        age_nxt[slot_c]   = '0;
        wr_tag_c          = 1'b1;
        if (!ev_c) occ_nxt = occ_r + OB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < W; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < W; i++) begin
        age_r[i] <= age_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_tag_c) tag_r[slot_c] <= req_tag_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_hit_r <= hit_r;
      res_ev_r  <= ev_c;
      res_evd_r <= ev_c && vic_dirty_r;
      res_evt_r <= ev_c ? 32'(vic_tag_r) : 32'd0;
    end
  end

  assign res_hit           = res_hit_r;
  assign res_evicted       = res_ev_r;
  assign res_evicted_dirty = res_evd_r;
  assign res_evicted_tag   = res_evt_r;

endmodule

/* hdl/lru_cache_set.sv */
// One set of a set-associative cache with true LRU replacement.
// The result is registered when the update state commits, after the lookup state.
// A new access can be taken in the update state that commits, but not during lookup.
// A result held back by the receiver stalls the update cycle and with it the input.
// Reset: all entries invalid, ages and occupancy zero, ways_in_use 8, allocate and
// write-back on; no clearing pass.
module lru_cache_set (
  input  logic                              clk,
  input  logic                              rst_n,
  lcs_in_if.sink                            in_ch,
  lcs_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [lcs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lcs_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  lcs_pkg::lcs_cmd_t cmd;

  lcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  lcs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_tag            (in_ch.tag),
    .in_is_write       (in_ch.is_write),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .res_hit           (out_ch.hit),
    .res_evicted       (out_ch.evicted),
    .res_evicted_dirty (out_ch.evicted_dirty),
    .res_evicted_tag   (out_ch.evicted_tag)
  );

`ifndef SYNTHESIS
  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && out_ch.valid |-> out_ch.ready)
    else $error("result overwritten before delivery");

  // A fresh result only appears after a commit
  a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.commit))
    else $error("result valid without commit");

  // An accepted item always goes to lookup next
  a_capture_then_look: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.look)
    else $error("accepted item skipped lookup");
`endif

endmodule
